// ===== hdl/sup_pkg.sv =====
// ----------------------------------------------------------------------------
// sup_pkg: shared types and constants of the unit propagation core
// Word layouts of both channels, the clause slot layout and command codes.
// ----------------------------------------------------------------------------
package sup_pkg;

  localparam int VAR_W      = 12;
  localparam int IDX_W      = 14;
  localparam int CNT_W      = 13;
  localparam int CFG_W      = 15;

  localparam int VAR_DEPTH_DEF    = 4096;
  localparam int CLAUSE_DEPTH_DEF = 16384;

  // Command codes.
  localparam logic [1:0] CMD_LOAD   = 2'd0;
  localparam logic [1:0] CMD_PROP   = 2'd1;
  localparam logic [1:0] CMD_ASSIGN = 2'd2;
  localparam logic [1:0] CMD_READ   = 2'd3;

  // Variable assignment codes.
  localparam logic [1:0] VAL_FREE  = 2'd0;
  localparam logic [1:0] VAL_FALSE = 2'd1;
  localparam logic [1:0] VAL_TRUE  = 2'd2;

  typedef struct packed {
    logic [1:0]       command;
    logic [IDX_W-1:0] clause_index;
    logic [VAR_W-1:0] lit_a_var;
    logic             lit_a_positive;
    logic [VAR_W-1:0] lit_b_var;
    logic             lit_b_positive;
    logic [VAR_W-1:0] lit_c_var;
    logic             lit_c_positive;
    logic [VAR_W-1:0] target_var;
    logic             target_value;
  } in_word_t;

  typedef struct packed {
    logic             status;
    logic [1:0]       var_value;
    logic [CNT_W-1:0] assigned_count;
  } out_word_t;

  // One literal: positive flag above the variable index.
  typedef struct packed {
    logic             positive;
    logic [VAR_W-1:0] vidx;
  } lit_t;

  // One clause slot: live flag, then literals c, b, a (a lowest).
  typedef struct packed {
    logic live;
    lit_t lit_c;
    lit_t lit_b;
    lit_t lit_a;
  } clause_t;

  // Evaluation of one clause against the current assignment.
  typedef struct packed {
    logic             sat;
    logic [1:0]       free_cnt;
    lit_t             free_lit;
  } eval_t;

endpackage

// ===== hdl/sup_ram.sv =====
// ----------------------------------------------------------------------------
// sup_ram: generic single port write, single port read RAM
// One write and one registered read per cycle; read data holds when idle.
// ----------------------------------------------------------------------------
module sup_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== hdl/sup_clause_eval.sv =====
// ----------------------------------------------------------------------------
// sup_clause_eval: evaluates one three-literal clause
// Reports whether the clause is satisfied, how many literals are free and
// which free literal comes last.
// ----------------------------------------------------------------------------
module sup_clause_eval
  import sup_pkg::*;
#(
  parameter int VAR_DEPTH = VAR_DEPTH_DEF
) (
  input  clause_t          clause,
  input  logic [2:0][1:0]  vals,
  output eval_t            eval
);

  lit_t       lits [3];
  logic [2:0] free;
  logic [2:0] truth;

  assign lits[0] = clause.lit_a;
  assign lits[1] = clause.lit_b;
  assign lits[2] = clause.lit_c;

  // A literal on a variable beyond the table is neither free nor true.
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      logic in_range;
      in_range = (32'(lits[j].vidx) < VAR_DEPTH);
      free[j]  = in_range && (vals[j] == VAL_FREE);
      truth[j] = in_range && (vals[j] != VAL_FREE) &&
                 ((vals[j] == VAL_TRUE) == lits[j].positive);
    end
  end

  always_comb begin
    eval.sat      = |truth;
    eval.free_cnt = 2'(free[0]) + 2'(free[1]) + 2'(free[2]);
    if (free[2]) begin
      eval.free_lit = lits[2];
    end else if (free[1]) begin
      eval.free_lit = lits[1];
    end else begin
      eval.free_lit = lits[0];
    end
  end

endmodule

// ===== hdl/sat_unit_propagation_core.sv =====
// ----------------------------------------------------------------------------
// sat_unit_propagation_core: unit propagation engine for 3-literal clauses
// Clause table and variable assignments live in two RAMs; a sequencer
// scans clauses, forces unit literals and repeats passes to a fixpoint.
// ----------------------------------------------------------------------------
// Usage. Command words enter on in_valid / in_stall and each produces exactly
// one result word on out_valid / out_stall; a word moves at an edge where
// valid is high and stall is low. The single register, num_clauses, is
// written through cfg_valid / cfg_ready; the user must write it only while
// the core is idle, since the core itself does not enforce this.
// A propagate or assign walks clauses 0 to num_clauses-1 per pass, with one
// clause read and, for a live slot, three variable reads on the single read
// port of each RAM, repeating passes until a pass forces nothing or a
// conflict appears. The core takes one command at a time; in_stall is high
// while it works. After reset a clearing pass marks every clause slot not
// live and every variable unassigned; in_stall stays high during it. A
// stalled receiver holds the result in the output register, and the next
// command is accepted meanwhile, though its result waits until the
// register frees.
// ----------------------------------------------------------------------------
module sat_unit_propagation_core
  import sup_pkg::*;
#(
  parameter int VAR_DEPTH    = VAR_DEPTH_DEF,
  parameter int CLAUSE_DEPTH = CLAUSE_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  in_word_t         in_word,
  output logic             out_valid,
  input  logic             out_stall,
  output out_word_t        out_word,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CFG_W-1:0] cfg_data
);

  localparam int VAW  = $clog2(VAR_DEPTH);
  localparam int CAW  = $clog2(CLAUSE_DEPTH);
  localparam int LW   = CAW + 1;
  localparam int MAXD = (VAR_DEPTH > CLAUSE_DEPTH) ? VAR_DEPTH : CLAUSE_DEPTH;
  localparam int CLW  = $clog2(MAXD);
  localparam int CLS_W = $bits(clause_t);

  localparam logic [3:0] S_CLEAR  = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_LOAD   = 4'd2;
  localparam logic [3:0] S_READ   = 4'd3;
  localparam logic [3:0] S_ASSIGN = 4'd4;
  localparam logic [3:0] S_PASS   = 4'd5;
  localparam logic [3:0] S_CLAUSE = 4'd6;
  localparam logic [3:0] S_VA     = 4'd7;
  localparam logic [3:0] S_VB     = 4'd8;
  localparam logic [3:0] S_VC     = 4'd9;
  localparam logic [3:0] S_NEXT   = 4'd10;
  localparam logic [3:0] S_RESP   = 4'd11;

  function automatic logic [VAW-1:0] var_addr(input logic [VAR_W-1:0] v);
    logic [31:0] w;
    w = 32'(v);
    return w[VAW-1:0];
  endfunction

  // Control and datapath registers.
  logic [3:0]       state_r,       state_nxt;
  logic [CLW-1:0]   clr_r,         clr_nxt;
  in_word_t         cmd_r,         cmd_nxt;
  logic [CAW-1:0]   ci_r,          ci_nxt;
  logic             changed_r,     changed_nxt;
  clause_t          clause_r,      clause_nxt;
  logic [1:0]       val_a_r,       val_a_nxt;
  logic [1:0]       val_b_r,       val_b_nxt;
  logic [CNT_W-1:0] count_r,       count_nxt;
  logic             status_r,      status_nxt;
  logic [1:0]       rvalue_r,      rvalue_nxt;
  logic             out_valid_r,   out_valid_nxt;
  out_word_t        out_word_r,    out_word_nxt;
  logic [CFG_W-1:0] num_clauses_r;

  // RAM ports.
  logic             cl_wr_en;
  logic [CAW-1:0]   cl_wr_addr;
  clause_t          cl_wr_data;
  logic             cl_rd_en;
  logic [CAW-1:0]   cl_rd_addr;
  clause_t          cl_rd_data;
  logic             va_wr_en;
  logic [VAW-1:0]   va_wr_addr;
  logic [1:0]       va_wr_data;
  logic             va_rd_en;
  logic [VAW-1:0]   va_rd_addr;
  logic [1:0]       va_rd_data;

  logic [LW-1:0]    limit;
  logic [31:0]      slot32;
  logic [31:0]      clr32;
  logic             slot_ok;
  logic             target_ok;
  logic             out_free;
  eval_t            eval;

  sup_ram #(
    .WIDTH (CLS_W),
    .DEPTH (CLAUSE_DEPTH)
  ) u_clause_ram (
    .clk     (clk),
    .wr_en   (cl_wr_en),
    .wr_addr (cl_wr_addr),
    .wr_data (cl_wr_data),
    .rd_en   (cl_rd_en),
    .rd_addr (cl_rd_addr),
    .rd_data (cl_rd_data)
  );

  sup_ram #(
    .WIDTH (2),
    .DEPTH (VAR_DEPTH)
  ) u_var_ram (
    .clk     (clk),
    .wr_en   (va_wr_en),
    .wr_addr (va_wr_addr),
    .wr_data (va_wr_data),
    .rd_en   (va_rd_en),
    .rd_addr (va_rd_addr),
    .rd_data (va_rd_data)
  );

  // The third variable value comes straight from the RAM output.
  sup_clause_eval #(
    .VAR_DEPTH (VAR_DEPTH)
  ) u_eval (
    .clause (clause_r),
    .vals   ({va_rd_data, val_b_r, val_a_r}),
    .eval   (eval)
  );

  // The scan covers num_clauses slots, but never more than the table holds.
  assign limit = (32'(num_clauses_r) > CLAUSE_DEPTH) ? LW'(CLAUSE_DEPTH)
                                                     : LW'(num_clauses_r);

  assign slot32    = 32'(cmd_r.clause_index);
  assign clr32     = 32'(clr_r);
  assign slot_ok   = (slot32 < CLAUSE_DEPTH);
  assign target_ok = (32'(cmd_r.target_var) < VAR_DEPTH);
  assign out_free  = !out_valid_r || !out_stall;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;
  assign cfg_ready = 1'b1;

  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    cmd_nxt       = cmd_r;
    ci_nxt        = ci_r;
    changed_nxt   = changed_r;
    clause_nxt    = clause_r;
    val_a_nxt     = val_a_r;
    val_b_nxt     = val_b_r;
    count_nxt     = count_r;
    status_nxt    = status_r;
    rvalue_nxt    = rvalue_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_word_nxt  = out_word_r;

    cl_wr_en   = 1'b0;
    cl_wr_addr = ci_r;
    cl_wr_data = clause_r;
    cl_rd_en   = 1'b0;
    cl_rd_addr = ci_r;
    va_wr_en   = 1'b0;
    va_wr_addr = var_addr(cmd_r.target_var);
    va_wr_data = VAL_FREE;
    va_rd_en   = 1'b0;
    va_rd_addr = var_addr(cmd_r.target_var);

    case (state_r)
      S_CLEAR: begin
        // Both tables are wiped together; the shorter one stops early.
        cl_wr_en   = (clr32 < CLAUSE_DEPTH);
        cl_wr_addr = clr32[CAW-1:0];
        cl_wr_data = '0;
        va_wr_en   = (clr32 < VAR_DEPTH);
        va_wr_addr = clr32[VAW-1:0];
        va_wr_data = VAL_FREE;
        clr_nxt    = clr_r + CLW'(1);
        if (clr32 == MAXD - 1) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd_nxt    = in_word;
          status_nxt = 1'b0;
          rvalue_nxt = VAL_FREE;
          va_rd_addr = var_addr(in_word.target_var);
          case (in_word.command)
            CMD_LOAD: begin
              state_nxt = S_LOAD;
            end
            CMD_PROP: begin
              state_nxt = S_PASS;
            end
            CMD_ASSIGN: begin
              va_rd_en  = 1'b1;
              state_nxt = S_ASSIGN;
            end
            default: begin
              va_rd_en  = 1'b1;
              state_nxt = S_READ;
            end
          endcase
        end
      end
      S_LOAD: begin
        cl_wr_en   = slot_ok;
        cl_wr_addr = slot32[CAW-1:0];
        cl_wr_data = '{live: 1'b1,
                       lit_c: '{positive: cmd_r.lit_c_positive, vidx: cmd_r.lit_c_var},
                       lit_b: '{positive: cmd_r.lit_b_positive, vidx: cmd_r.lit_b_var},
                       lit_a: '{positive: cmd_r.lit_a_positive, vidx: cmd_r.lit_a_var}};
        state_nxt  = S_RESP;
      end
      S_READ: begin
        if (target_ok) begin
          rvalue_nxt = va_rd_data;
        end
        state_nxt = S_RESP;
      end
      S_ASSIGN: begin
        // An already fixed variable keeps its value; propagation runs anyway.
        if (target_ok && (va_rd_data == VAL_FREE)) begin
          va_wr_en   = 1'b1;
          va_wr_data = cmd_r.target_value ? VAL_TRUE : VAL_FALSE;
          count_nxt  = count_r + CNT_W'(1);
        end
        state_nxt = S_PASS;
      end
      S_PASS: begin
        ci_nxt      = '0;
        changed_nxt = 1'b0;
        if (limit == '0) begin
          state_nxt = S_RESP;
        end else begin
          cl_rd_en   = 1'b1;
          cl_rd_addr = '0;
          state_nxt  = S_CLAUSE;
        end
      end
      S_CLAUSE: begin
        clause_nxt = cl_rd_data;
        if (cl_rd_data.live) begin
          va_rd_en   = 1'b1;
          va_rd_addr = var_addr(cl_rd_data.lit_a.vidx);
          state_nxt  = S_VA;
        end else begin
          state_nxt  = S_NEXT;
        end
      end
      S_VA: begin
        val_a_nxt  = va_rd_data;
        va_rd_en   = 1'b1;
        va_rd_addr = var_addr(clause_r.lit_b.vidx);
        state_nxt  = S_VB;
      end
      S_VB: begin
        val_b_nxt  = va_rd_data;
        va_rd_en   = 1'b1;
        va_rd_addr = var_addr(clause_r.lit_c.vidx);
        state_nxt  = S_VC;
      end
      S_VC: begin
        if (eval.sat) begin
          // Satisfied clauses drop out of later scans.
          cl_wr_en        = 1'b1;
          cl_wr_data      = clause_r;
          cl_wr_data.live = 1'b0;
          state_nxt       = S_NEXT;
        end else if (eval.free_cnt == 2'd0) begin
          status_nxt = 1'b1;
          state_nxt  = S_RESP;
        end else if (eval.free_cnt == 2'd1) begin
          // A unit clause forces its last free literal true right away, so
          // the following clauses of this pass already see it.
          va_wr_en    = 1'b1;
          va_wr_addr  = var_addr(eval.free_lit.vidx);
          va_wr_data  = eval.free_lit.positive ? VAL_TRUE : VAL_FALSE;
          count_nxt   = count_r + CNT_W'(1);
          changed_nxt = 1'b1;
          state_nxt   = S_NEXT;
        end else begin
          state_nxt = S_NEXT;
        end
      end
      S_NEXT: begin
        if ({1'b0, ci_r} == limit - LW'(1)) begin
          state_nxt = changed_r ? S_PASS : S_RESP;
        end else begin
          ci_nxt     = ci_r + CAW'(1);
          cl_rd_en   = 1'b1;
          cl_rd_addr = ci_r + CAW'(1);
          state_nxt  = S_CLAUSE;
        end
      end
      S_RESP: begin
        if (out_free) begin
          out_word_nxt  = '{status: status_r, var_value: rvalue_r,
                            assigned_count: count_r};
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_CLEAR;
      clr_r         <= '0;
      count_r       <= '0;
      out_valid_r   <= 1'b0;
      num_clauses_r <= '0;
      changed_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      changed_r   <= changed_nxt;
      if (cfg_valid && cfg_ready) begin
        num_clauses_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    ci_r       <= ci_nxt;
    clause_r   <= clause_nxt;
    val_a_r    <= val_a_nxt;
    val_b_r    <= val_b_nxt;
    status_r   <= status_nxt;
    rvalue_r   <= rvalue_nxt;
    out_word_r <= out_word_nxt;
  end

endmodule

// ===== test/sat_unit_propagation_core_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sat_unit_propagation_core_tb: self-checking bench for the propagation core
// Command words go in on the in_ channel and the core's result words come
// back on the out_ channel. The result words are compared field by field
// with those of a behavioral copy of the clause table and the variable
// assignments. The run covers every command, several scan lengths from
// zero to beyond the table size, and random sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module sat_unit_propagation_core_tb
  import sup_pkg::*;
();

  // Longest stretch of cycles in which no word moves on any channel. The
  // slowest command scans the full table for up to three passes, and the
  // clearing pass after reset is quiet as well.
  localparam int QUIET_LIMIT = 400000;

  // --------------------------------------------------------------------------
  // Behavioral copy of the core. note_command applies one accepted command
  // word and queues the result word it owes; check_word compares a result
  // word from the core with the oldest owed one.
  // --------------------------------------------------------------------------
  class bcp_tracker;
    clause_t          slot_tab[CLAUSE_DEPTH_DEF];
    logic [1:0]       var_tab[VAR_DEPTH_DEF];
    int unsigned      n_assigned;
    logic [CFG_W-1:0] scan_len;
    out_word_t        owed_words[$];
    int               n_errors;
    int               n_forced;
    int               n_conflicts;
    int               n_cmds[4];

    function new();
      foreach (slot_tab[i]) slot_tab[i] = '0;
      foreach (var_tab[i]) var_tab[i] = VAL_FREE;
      foreach (n_cmds[i]) n_cmds[i] = 0;
      n_assigned  = 0;
      scan_len    = '0;
      n_errors    = 0;
      n_forced    = 0;
      n_conflicts = 0;
    endfunction

    function void set_scan_length(logic [CFG_W-1:0] len);
      scan_len = len;
    endfunction

    // Repeats passes over the live clauses until one forces nothing.
    // Returns 1 when a clause has no free literal and is not satisfied.
    function logic settle_clauses();
      int unsigned lim;
      bit          changed;
      lim = (scan_len > CLAUSE_DEPTH_DEF) ? CLAUSE_DEPTH_DEF : scan_len;
      changed = 1'b1;
      while (changed) begin
        changed = 1'b0;
        for (int unsigned ci = 0; ci < lim; ci++) begin
          lit_t lits[3];
          logic sat;
          int   nfree;
          lit_t pick;
          if (!slot_tab[ci].live) continue;
          lits[0] = slot_tab[ci].lit_a;
          lits[1] = slot_tab[ci].lit_b;
          lits[2] = slot_tab[ci].lit_c;
          sat   = 1'b0;
          nfree = 0;
          pick  = '0;
          // Each literal counts on its own, even when a variable repeats.
          foreach (lits[j]) begin
            if (int'(lits[j].vidx) >= VAR_DEPTH_DEF) continue;
            if (var_tab[lits[j].vidx] == VAL_FREE) begin
              nfree++;
              pick = lits[j];
            end else if ((var_tab[lits[j].vidx] == VAL_TRUE) == lits[j].positive) begin
              sat = 1'b1;
            end
          end
          if (sat) begin
            slot_tab[ci].live = 1'b0;
            continue;
          end
          if (nfree == 0) return 1'b1;
          if (nfree == 1) begin
            var_tab[pick.vidx] = pick.positive ? VAL_TRUE : VAL_FALSE;
            n_assigned++;
            n_forced++;
            changed = 1'b1;
          end
        end
      end
      return 1'b0;
    endfunction

    function void note_command(in_word_t w);
      out_word_t r;
      r = '0;
      n_cmds[w.command]++;
      case (w.command)
        CMD_LOAD: begin
          // A load overwrites the slot and makes it live.
          slot_tab[w.clause_index].live           = 1'b1;
          slot_tab[w.clause_index].lit_a.vidx     = w.lit_a_var;
          slot_tab[w.clause_index].lit_a.positive = w.lit_a_positive;
          slot_tab[w.clause_index].lit_b.vidx     = w.lit_b_var;
          slot_tab[w.clause_index].lit_b.positive = w.lit_b_positive;
          slot_tab[w.clause_index].lit_c.vidx     = w.lit_c_var;
          slot_tab[w.clause_index].lit_c.positive = w.lit_c_positive;
        end
        CMD_PROP: r.status = settle_clauses();
        CMD_ASSIGN: begin
          // A variable that is already fixed keeps its value.
          if (var_tab[w.target_var] == VAL_FREE) begin
            var_tab[w.target_var] = w.target_value ? VAL_TRUE : VAL_FALSE;
            n_assigned++;
          end
          r.status = settle_clauses();
        end
        CMD_READ: r.var_value = var_tab[w.target_var];
      endcase
      if (r.status) n_conflicts++;
      r.assigned_count = n_assigned[CNT_W-1:0];
      owed_words.push_back(r);
    endfunction

    function void check_word(out_word_t got);
      out_word_t want;
      if (owed_words.size() == 0) begin
        $display("%0t: result word %p arrived with none outstanding", $time, got);
        n_errors++;
        return;
      end
      want = owed_words.pop_front();
      if (got.status !== want.status) begin
        $display("%0t: status expected %0d, got %0d", $time, want.status, got.status);
        n_errors++;
      end
      if (got.var_value !== want.var_value) begin
        $display("%0t: var_value expected %0d, got %0d", $time, want.var_value,
                 got.var_value);
        n_errors++;
      end
      if (got.assigned_count !== want.assigned_count) begin
        $display("%0t: assigned_count expected %0d, got %0d", $time,
                 want.assigned_count, got.assigned_count);
        n_errors++;
      end
    endfunction
  endclass

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_stall;
  in_word_t         in_word;
  logic             out_valid;
  logic             out_stall;
  out_word_t        out_word;
  logic             cfg_valid;
  logic             cfg_ready;
  logic [CFG_W-1:0] cfg_data;

  bcp_tracker tracker;
  int         send_idle_pct;
  int         stall_pct;
  int         quiet_cycles;

  sat_unit_propagation_core i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // The receiver stalls at random, one decision per cycle.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // Every handshake is observed here, on values sampled at the clock edge,
  // so the drivers never have to tell the tracker anything. The watchdog
  // counts edges at which no word moved on any channel.
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) tracker.set_scan_length(cfg_data);
      if (in_valid && !in_stall) tracker.note_command(in_word);
      if (out_valid && !out_stall) tracker.check_word(out_word);
      if ((cfg_valid && cfg_ready) || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t: no word moved for %0d cycles", $time, QUIET_LIMIT);
        $display("[sat_unit_propagation_core] ERROR");
        $finish;
      end
    end
  end

  // Offers one command word and returns at the edge that accepts it. The
  // valid stays high afterwards, so back-to-back words never lower it; it is
  // only lowered for a sender gap or by drain_results.
  task automatic send_word(input in_word_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Writes the scan length register; first during the clearing pass, then only while the core is idle.
  task automatic write_scan_length(input logic [CFG_W-1:0] len);
    cfg_valid <= 1'b1;
    cfg_data  <= len;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Stops sending and waits until every owed result word has come back.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (tracker.owed_words.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  function automatic in_word_t clause_word(input int slot, input int av, input bit ap,
                                           input int bv, input bit bp,
                                           input int cv, input bit cp);
    in_word_t w;
    w                = '0;
    w.command        = CMD_LOAD;
    w.clause_index   = IDX_W'(slot);
    w.lit_a_var      = VAR_W'(av);
    w.lit_a_positive = ap;
    w.lit_b_var      = VAR_W'(bv);
    w.lit_b_positive = bp;
    w.lit_c_var      = VAR_W'(cv);
    w.lit_c_positive = cp;
    return w;
  endfunction

  function automatic in_word_t var_word(input logic [1:0] cmd, input int v, input bit val);
    in_word_t w;
    w              = '0;
    w.command      = cmd;
    w.target_var   = VAR_W'(v);
    w.target_value = val;
    return w;
  endfunction

  // Mostly a small window of variables, so clauses share variables and
  // actually propagate; now and then any variable at all.
  function automatic logic [VAR_W-1:0] pool_var(input int base);
    if ($urandom_range(9) == 0) return VAR_W'($urandom);
    return VAR_W'(base + $urandom_range(0, 19));
  endfunction

  // Random command word. Most words are loads into or just past the scanned
  // slots and assigns on the shared window; one in five is noise in every field.
  function automatic in_word_t random_word(input int nc, input int base);
    logic [95:0] noise;
    in_word_t    w;
    int          pct;
    noise = {$urandom, $urandom, $urandom};
    w     = noise[$bits(in_word_t)-1:0];
    if ($urandom_range(99) < 80) begin
      pct = $urandom_range(99);
      if (pct < 40) w.command = CMD_LOAD;
      else if (pct < 55) w.command = CMD_PROP;
      else if (pct < 85) w.command = CMD_ASSIGN;
      else w.command = CMD_READ;
      if ($urandom_range(9) != 0) w.clause_index = IDX_W'($urandom_range(0, nc + 1));
      w.lit_a_var  = pool_var(base);
      w.lit_b_var  = pool_var(base);
      w.lit_c_var  = pool_var(base);
      w.target_var = pool_var(base);
    end
    return w;
  endfunction

  initial begin
    int nc;
    in_valid      = 1'b0;
    in_word       = '0;
    cfg_valid     = 1'b0;
    cfg_data      = '0;
    out_stall     = 1'b0;
    rst_n         = 1'b0;
    send_idle_pct = 0;
    stall_pct     = 0;
    quiet_cycles  = 0;
    tracker       = new();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Scan length zero: propagation sees no clause at all. Reads of fresh
    // variables at both ends of the range, loads at both ends of the table.
    write_scan_length('0);
    send_word(var_word(CMD_READ, 0, 1'b0));
    send_word(var_word(CMD_READ, 4095, 1'b1));
    send_word(clause_word(0, 1, 1'b1, 2, 1'b1, 3, 1'b1));
    send_word(clause_word(16383, 4095, 1'b0, 0, 1'b0, 7, 1'b1));
    send_word(var_word(CMD_PROP, 0, 1'b0));
    send_word(var_word(CMD_ASSIGN, 1, 1'b0));
    drain_results();

    // Full table scan. Each command here costs one or two passes over all
    // slots, so only a handful are sent: a unit clause at slot 0 and another
    // at the last slot, which is only reached at this length.
    write_scan_length(CFG_W'(CLAUSE_DEPTH_DEF));
    send_word(var_word(CMD_PROP, 0, 1'b0));
    send_word(var_word(CMD_ASSIGN, 2, 1'b0));
    send_word(var_word(CMD_ASSIGN, 4095, 1'b1));
    send_word(var_word(CMD_ASSIGN, 0, 1'b1));
    drain_results();

    // A length beyond the table must stop the scan at the last slot.
    write_scan_length('1);
    send_word(clause_word(16382, 8, 1'b1, 9, 1'b1, 7, 1'b0));
    send_word(var_word(CMD_ASSIGN, 8, 1'b0));
    drain_results();

    // Small table: a contradiction that persists, then is cleared by
    // overwriting the slot with a clause that repeats one variable. Also an
    // assign of an already fixed variable and a clause satisfied on load.
    write_scan_length(CFG_W'(4));
    send_word(clause_word(1, 1, 1'b1, 2, 1'b1, 3, 1'b0));
    send_word(var_word(CMD_PROP, 0, 1'b0));
    send_word(var_word(CMD_ASSIGN, 10, 1'b1));
    send_word(clause_word(1, 20, 1'b1, 20, 1'b1, 1, 1'b1));
    send_word(var_word(CMD_PROP, 0, 1'b0));
    send_word(var_word(CMD_ASSIGN, 1, 1'b1));
    send_word(clause_word(2, 21, 1'b0, 22, 1'b1, 4095, 1'b1));
    send_word(clause_word(3, 23, 1'b1, 24, 1'b1, 25, 1'b1));
    send_word(var_word(CMD_ASSIGN, 23, 1'b0));
    send_word(var_word(CMD_ASSIGN, 24, 1'b0));
    send_word(var_word(CMD_READ, 25, 1'b0));
    send_word(var_word(CMD_READ, 9, 1'b0));
    drain_results();

    // Random part in four pacing phases. Each phase gets its own scan
    // length and its own window of variables, so fresh unassigned variables
    // are always around even though assignments are never undone.
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  stall_pct = 0;  nc = 1; end
        1: begin send_idle_pct = 66; stall_pct = 0;  nc = $urandom_range(6, 16); end
        2: begin send_idle_pct = 0;  stall_pct = 66; nc = 24; end
        default: begin send_idle_pct = 37; stall_pct = 37; nc = $urandom_range(2, 10); end
      endcase
      write_scan_length(CFG_W'(nc));
      for (int k = 0; k < 25; k++) begin
        // Once, the sender holds off until the core has answered everything.
        if (ph == 1 && k == 12) drain_results();
        send_word(random_word(nc, 100 + 40 * ph));
      end
      drain_results();
    end

    stall_pct = 0;
    repeat (32) @(posedge clk);
    $display("Commands: %0d loads, %0d propagates, %0d assigns, %0d reads.",
             tracker.n_cmds[CMD_LOAD], tracker.n_cmds[CMD_PROP],
             tracker.n_cmds[CMD_ASSIGN], tracker.n_cmds[CMD_READ]);
    $display("Forced literals: %0d, contradictions: %0d, scan lengths 0 to 32767.",
             tracker.n_forced, tracker.n_conflicts);
    if (tracker.n_errors == 0 && tracker.owed_words.size() == 0) begin
      $display("[sat_unit_propagation_core] OK");
    end else begin
      $display("[sat_unit_propagation_core] ERROR");
    end
    $finish;
  end

endmodule
